// ===== design/gtp_pkg.sv =====
`default_nettype none

package gtp_pkg;

    localparam int Q_W              = 32;
    localparam int ACC_W            = 64;
    localparam int COEFF_W          = 17;
    localparam int BLEN_W           = 12;
    localparam int POWER_W          = 56;
    localparam int POWER_SHIFT      = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = COEFF_W;

    localparam logic [BLEN_W-1:0]    BLEN_RESET = BLEN_W'(410);
    localparam logic [CFG_IDX_W-1:0] REG_COEFF  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLEN   = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        STEP_WAIT,
        STEP_MUL_FB,
        STEP_RECUR,
        STEP_SQ1,
        STEP_SQ2,
        STEP_CROSS,
        STEP_TERM,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        A_COEFF,
        A_Q1,
        A_Q2,
        A_PROD
    } a_sel_t;

    typedef enum logic {
        B_Q1,
        B_Q2
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_SEQ,
        JMP_COND,
        JMP_ALWAYS
    } jmp_t;

    typedef struct packed {
        logic    take_in;
        logic    recur;
        logic    emit;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        jmp_t    jmp;
        step_t   target;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } ctrl_t;

    typedef struct packed {
        logic blk_end;
        logic out_free;
    } status_t;

    // microprogram: three steps per sample, five more to close a block
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{take_in: 1'b0, recur: 1'b0, emit: 1'b0, a_sel: A_COEFF, b_sel: B_Q1,
              acc_op: ACC_HOLD, jmp: JMP_SEQ, target: STEP_WAIT};
        case (s)
            STEP_WAIT:   w.take_in = 1'b1;
            STEP_MUL_FB:
            begin
                w.a_sel = A_COEFF;
                w.b_sel = B_Q1;
            end
            STEP_RECUR:
            begin
                w.recur  = 1'b1;
                w.jmp    = JMP_COND;
                w.target = STEP_WAIT;
            end
            STEP_SQ1:
            begin
                w.a_sel = A_Q1;
                w.b_sel = B_Q1;
            end
            STEP_SQ2:
            begin
                w.acc_op = ACC_LOAD;
                w.a_sel  = A_Q2;
                w.b_sel  = B_Q2;
            end
            STEP_CROSS:
            begin
                w.acc_op = ACC_ADD;
                w.a_sel  = A_COEFF;
                w.b_sel  = B_Q1;
            end
            STEP_TERM:
            begin
                w.a_sel = A_PROD;
                w.b_sel = B_Q2;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:     w.jmp = JMP_ALWAYS;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/gtp_sequencer.sv =====
`default_nettype none

module gtp_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    input  wire gtp_pkg::status_t status,
    output gtp_pkg::ctrl_t        ctrl
);

    gtp_pkg::step_t  step_reg;
    gtp_pkg::step_t  step_next;
    gtp_pkg::ucode_t uc;
    logic            go;

    assign uc = gtp_pkg::ucode_rom(step_reg);

    // step stalls waiting for a sample or for the output slot
    always_comb
    begin
        go = 1'b1;
        if (uc.take_in && !sample_valid)
        begin
            go = 1'b0;
        end
        if (uc.emit && !status.out_free)
        begin
            go = 1'b0;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            case (uc.jmp)
                gtp_pkg::JMP_SEQ:    step_next = gtp_pkg::step_t'(step_reg + 3'd1);
                gtp_pkg::JMP_COND:
                begin
                    if (status.blk_end)
                    begin
                        step_next = gtp_pkg::step_t'(step_reg + 3'd1);
                    end
                    else
                    begin
                        step_next = uc.target;
                    end
                end
                gtp_pkg::JMP_ALWAYS: step_next = uc.target;
                default:             step_next = gtp_pkg::STEP_WAIT;
            endcase
        end
    end

    always_comb
    begin
        ctrl.uc = uc;
        ctrl.go = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= gtp_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/gtp_datapath.sv =====
`default_nettype none

module gtp_datapath #(
    parameter int SAMPLE_WIDTH    = gtp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire gtp_pkg::ctrl_t                       ctrl,
    output gtp_pkg::status_t                          status,
    input  wire logic                                 cfg_we,
    input  wire logic        [gtp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic        [gtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        sample,
    output logic signed      [gtp_pkg::POWER_W-1:0]    power,
    output logic                                      power_valid,
    input  wire logic                                 power_ready
);

    // widest multiplier operand is the shifted q1*coeff term
    localparam int MUL_A_W = gtp_pkg::Q_W + gtp_pkg::COEFF_W - COEFF_FRAC_BITS;
    localparam int MUL_P_W = MUL_A_W + gtp_pkg::Q_W;

    logic signed [gtp_pkg::COEFF_W-1:0] coeff_reg;
    logic        [gtp_pkg::BLEN_W-1:0]  blen_reg;
    logic signed [SAMPLE_WIDTH-1:0]     sample_reg;
    logic signed [gtp_pkg::Q_W-1:0]     q1_reg;
    logic signed [gtp_pkg::Q_W-1:0]     q2_reg;
    logic        [gtp_pkg::BLEN_W-1:0]  count_reg;
    logic signed [gtp_pkg::ACC_W-1:0]   prod_reg;
    logic signed [gtp_pkg::ACC_W-1:0]   acc_reg;
    logic signed [gtp_pkg::POWER_W-1:0] power_reg;
    logic                               power_valid_reg;

    logic signed [MUL_A_W-1:0]          op_a;
    logic signed [gtp_pkg::Q_W-1:0]     op_b;
    logic signed [MUL_P_W-1:0]          mul_out;
    logic signed [gtp_pkg::ACC_W-1:0]   prod_shr;
    logic signed [gtp_pkg::Q_W-1:0]     q_new;
    logic        [gtp_pkg::BLEN_W-1:0]  count_inc;
    logic signed [gtp_pkg::ACC_W-1:0]   acc_next;
    logic signed [gtp_pkg::ACC_W-1:0]   power_sum;
    logic                               take;
    logic                               fire_emit;

    assign take      = ctrl.go && ctrl.uc.take_in;
    assign fire_emit = ctrl.go && ctrl.uc.emit;
    assign prod_shr  = prod_reg >>> COEFF_FRAC_BITS;

    always_comb
    begin
        case (ctrl.uc.a_sel)
            gtp_pkg::A_COEFF: op_a = (MUL_A_W)'(coeff_reg);
            gtp_pkg::A_Q1:    op_a = (MUL_A_W)'(q1_reg);
            gtp_pkg::A_Q2:    op_a = (MUL_A_W)'(q2_reg);
            gtp_pkg::A_PROD:  op_a = prod_shr[MUL_A_W-1:0];
            default:          op_a = '0;
        endcase
        case (ctrl.uc.b_sel)
            gtp_pkg::B_Q1: op_b = q1_reg;
            gtp_pkg::B_Q2: op_b = q2_reg;
            default:       op_b = '0;
        endcase
    end

    assign mul_out = (MUL_P_W)'(op_a) * (MUL_P_W)'(op_b);

    // recurrence wraps at 32 bits
    assign q_new = gtp_pkg::Q_W'(sample_reg) + prod_shr[gtp_pkg::Q_W-1:0] - q2_reg;

    assign count_inc      = count_reg + gtp_pkg::BLEN_W'(1);
    assign status.blk_end = (count_inc >= blen_reg) || (count_inc == '0);
    assign status.out_free = !power_valid_reg || power_ready;

    assign power_sum = acc_reg - prod_reg;

    always_comb
    begin
        case (ctrl.uc.acc_op)
            gtp_pkg::ACC_HOLD: acc_next = acc_reg;
            gtp_pkg::ACC_LOAD: acc_next = prod_reg;
            gtp_pkg::ACC_ADD:  acc_next = acc_reg + prod_reg;
            gtp_pkg::ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg       <= '0;
            blen_reg        <= gtp_pkg::BLEN_RESET;
            q1_reg          <= '0;
            q2_reg          <= '0;
            count_reg       <= '0;
            power_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    gtp_pkg::REG_COEFF: coeff_reg <= cfg_wdata;
                    gtp_pkg::REG_BLEN:  blen_reg  <= cfg_wdata[gtp_pkg::BLEN_W-1:0];
                    default:            ;
                endcase
            end
            if (ctrl.go && ctrl.uc.recur)
            begin
                q2_reg    <= q1_reg;
                q1_reg    <= q_new;
                count_reg <= count_inc;
            end
            if (fire_emit)
            begin
                q1_reg    <= '0;
                q2_reg    <= '0;
                count_reg <= '0;
            end
            if (fire_emit)
            begin
                power_valid_reg <= 1'b1;
            end
            else if (power_ready)
            begin
                power_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg <= sample;
        end
        if (ctrl.go)
        begin
            prod_reg <= mul_out[gtp_pkg::ACC_W-1:0];
            acc_reg  <= acc_next;
        end
        if (fire_emit)
        begin
            power_reg <= power_sum[gtp_pkg::ACC_W-1:gtp_pkg::POWER_SHIFT];
        end
    end

    assign power       = power_reg;
    assign power_valid = power_valid_reg;

endmodule

`default_nettype wire

// ===== design/goertzel_tone_power.sv =====
// Goertzel single-tone power detector. Each sample word passes the accept, feedback product
// and state update steps; after the last sample of a block the microprogram forms
// q1*q1 + q2*q2 - ((q1*coeff) >>> frac) * q2 and loads the power word. All products come from
// a single shared multiplier, which the microprogram steps through one product per cycle
// while no step stalls. The power word sits in an output register; the next block starts at
// once, and only its final step waits if the previous word has not been taken. Write coeff
// and block_len only while the block is idle.
`default_nettype none

module goertzel_tone_power #(
    parameter int SAMPLE_WIDTH    = gtp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = gtp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic        [gtp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic        [gtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        sample,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    output logic signed      [gtp_pkg::POWER_W-1:0]    power,
    output logic                                      power_valid,
    input  wire logic                                 power_ready
);

    gtp_pkg::ctrl_t   ctrl;
    gtp_pkg::status_t status;

    gtp_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .status       (status),
        .ctrl         (ctrl)
    );

    gtp_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .sample      (sample),
        .power       (power),
        .power_valid (power_valid),
        .power_ready (power_ready)
    );

    assign sample_ready = ctrl.uc.take_in;

endmodule

`default_nettype wire

// ===== design/gtp_checker.sv =====
`default_nettype none

module gtp_checker #(
    parameter int SAMPLE_WIDTH = gtp_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic signed [SAMPLE_WIDTH-1:0]     sample,
    input wire logic                              sample_valid,
    input wire logic                              sample_ready,
    input wire logic signed [gtp_pkg::POWER_W-1:0] power,
    input wire logic                              power_valid,
    input wire logic                              power_ready
);

    // a waiting sample word stays put until it is taken
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_ready) |=> (sample_valid && $stable(sample)))
        else $error("sample word dropped or changed while waiting");

    // a sample word is processed before the next one is taken
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample_ready high right after an accepted word");

    // a power word is loaded only at the end of block math, never in the accept cycle
    a_power_after_math: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(power_valid) |-> $past(!sample_ready))
        else $error("power word appeared straight after a sample accept");

    // after a sample accept, the feedback product and state update steps come before any power word load
    a_power_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !$rose(power_valid) ##1 !$rose(power_valid))
        else $error("power word loaded too soon after a sample accept");

    a_power_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (power_valid && !power_ready) |=> (power_valid && $stable(power)))
        else $error("power word dropped or changed while stalled");

endmodule

bind goertzel_tone_power gtp_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .power        (power),
    .power_valid  (power_valid),
    .power_ready  (power_ready)
);

`default_nettype wire
